@@ hdl/tdm_audio_slot_pattern_and_capture_defines.svh @@
// Assertion helpers for the TDM slot pattern and capture block.
`ifndef TDM_AUDIO_SLOT_PATTERN_AND_CAPTURE_DEFINES_SVH
`define TDM_AUDIO_SLOT_PATTERN_AND_CAPTURE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TDMASP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define TDMASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tdmasp_pkg.sv @@
`default_nettype none

package tdmasp_pkg;

  typedef enum logic [2:0] {
    REG_WORD_LEN    = 3'd0,
    REG_SLOT_COUNT  = 3'd1,
    REG_RX_MASK     = 3'd2,
    REG_TX_MASK     = 3'd3,
    REG_PAT_START   = 3'd4,
    REG_PAT_END     = 3'd5,
    REG_PAT_STEP    = 3'd6,
    REG_SAMPLE_LIM  = 3'd7
  } cfg_reg_e;

  localparam int          CfgWidth   = 32;
  localparam int          LimitWidth = 17;
  localparam int          MaskWidth  = 8;
  localparam logic [1:0]  DRIVE_X    = 2'd3;
  // data line is high when line bits 3..2 read as one
  localparam logic [1:0]  LINE_ONE   = 2'd1;

  localparam logic [5:0]  WORD_LEN_RST   = 6'd16;
  localparam logic [3:0]  SLOT_COUNT_RST = 4'd2;
  localparam logic [31:0] PAT_END_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] PAT_STEP_RST   = 32'd1;

endpackage

`default_nettype wire

@@ hdl/tdm_audio_slot_pattern_and_capture.sv @@
// TDM serial-audio slave: each request is one bit-clock edge; only rising edges
// act. Inside a frame every rising edge gives one result (driven bit, and a
// captured word when one completes); other edges give none. A request passes
// through an input register and one combinational step into the result
// register, so the block takes one edge per clock cycle unless a stalled
// result blocks it; a stalled output holds the request in the input register.
// The per-slot ramp wrap test (one 32-bit subtract and compare) sets the
// cycle. Configuration writes take effect at once and are meant for idle
// periods.
`default_nettype none

module tdm_audio_slot_pattern_and_capture
  import tdmasp_pkg::*;
#(
  parameter int MAX_SLOTS    = 8,
  parameter int FRAME_DELAY  = 1,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [2:0]              cfg_index_i,
  input  wire logic [CfgWidth-1:0]     cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    clock_level_i,
  input  wire logic                    word_select_i,
  input  wire logic [3:0]              line_bits_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   drive_value_o,
  output logic                         sample_valid_o,
  output logic [SAMPLE_WIDTH-1:0]      sample_value_o,
  output logic [2:0]                   sample_slot_o
);

  `include "tdm_audio_slot_pattern_and_capture_defines.svh"

  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCW = $clog2(MAX_SLOTS + 1);
  localparam int BW  = $clog2(SAMPLE_WIDTH + 1);
  localparam int IW  = $clog2(SAMPLE_WIDTH);
  localparam int DW  = (FRAME_DELAY > 0) ? $clog2(FRAME_DELAY + 1) : 1;

  // configuration
  logic [5:0]                   wlen_q, wlen_d;
  logic [3:0]                   slot_count_q, slot_count_d;
  logic [MaskWidth-1:0]         rx_mask_q, rx_mask_d;
  logic [MaskWidth-1:0]         tx_mask_q, tx_mask_d;
  logic [31:0]                  pat_start_q, pat_start_d;
  logic [31:0]                  pat_end_q, pat_end_d;
  logic [31:0]                  pat_step_q, pat_step_d;
  logic signed [LimitWidth-1:0] limit_q, limit_d;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic       clk_lvl_q, ws_q;
  logic [3:0] lines_q;

  // frame control
  logic          last_ws_q, last_ws_d;
  logic [DW-1:0] delay_q, delay_d;
  logic          in_frame_q, in_frame_d;
  logic [BW-1:0] sbl_q, sbl_d;
  logic [SW-1:0] cs_q, cs_d;

  // per-slot state
  logic [31:0]                  ramp_q   [MAX_SLOTS], ramp_d   [MAX_SLOTS];
  logic [SAMPLE_WIDTH-1:0]      oshift_q [MAX_SLOTS], oshift_d [MAX_SLOTS];
  logic [BW-1:0]                obl_q    [MAX_SLOTS], obl_d    [MAX_SLOTS];
  logic signed [LimitWidth-1:0] sl_q     [MAX_SLOTS], sl_d     [MAX_SLOTS];
  logic [SAMPLE_WIDTH-1:0]      ishift_q [MAX_SLOTS], ishift_d [MAX_SLOTS];
  logic [BW-1:0]                ibl_q    [MAX_SLOTS], ibl_d    [MAX_SLOTS];

  // result register
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              drive_q, drive_d;
  logic                    svalid_q, svalid_d;
  logic [SAMPLE_WIDTH-1:0] svalue_q, svalue_d;
  logic [2:0]              sslot_q, sslot_d;

  logic                 fire;
  logic                 has_res;
  logic [BW-1:0]        eff_word;
  logic [SCW-1:0]       eff_slots;
  logic [MAX_SLOTS-1:0] rx_vec, tx_vec;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_en
    if (g < MaskWidth) begin : g_map
      assign rx_vec[g] = rx_mask_q[g];
      assign tx_vec[g] = tx_mask_q[g];
    end else begin : g_none
      assign rx_vec[g] = 1'b0;
      assign tx_vec[g] = 1'b0;
    end
  end

  assign eff_word = (wlen_q == 6'd0) ? BW'(1) :
                    (wlen_q > 6'(SAMPLE_WIDTH)) ? BW'(SAMPLE_WIDTH) :
                    BW'(wlen_q);
  assign eff_slots = (slot_count_q == 4'd0) ? SCW'(1) :
                     ({1'b0, slot_count_q} > 5'(MAX_SLOTS)) ? SCW'(MAX_SLOTS) :
                     SCW'(slot_count_q);

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    logic                         edge_det, begin_fr, frame, dbit;
    logic [DW-1:0]                delay;
    logic [BW-1:0]                sbl;
    logic [SW-1:0]                cs;
    logic [SCW-1:0]               nxt;
    logic [31:0]                  ramp;
    logic [SAMPLE_WIDTH-1:0]      oshift, ishift;
    logic [BW-1:0]                obl, ibl;
    logic signed [LimitWidth-1:0] sl;
    logic [IW-1:0]                msb;
    logic [MaskWidth-1:0]         rising;

    wlen_d       = wlen_q;
    slot_count_d = slot_count_q;
    rx_mask_d    = rx_mask_q;
    tx_mask_d    = tx_mask_q;
    pat_start_d  = pat_start_q;
    pat_end_d    = pat_end_q;
    pat_step_d   = pat_step_q;
    limit_d      = limit_q;
    last_ws_d    = last_ws_q;
    delay_d      = delay_q;
    in_frame_d   = in_frame_q;
    sbl_d        = sbl_q;
    cs_d         = cs_q;
    ramp_d       = ramp_q;
    oshift_d     = oshift_q;
    obl_d        = obl_q;
    sl_d         = sl_q;
    ishift_d     = ishift_q;
    ibl_d        = ibl_q;
    has_res      = 1'b0;
    drive_d      = DRIVE_X;
    svalid_d     = 1'b0;
    svalue_d     = '0;
    sslot_d      = '0;

    edge_det = ws_q && !last_ws_q;
    begin_fr = 1'b0;
    delay    = edge_det ? DW'(FRAME_DELAY) : delay_q;
    if (edge_det && (FRAME_DELAY == 0)) begin
      begin_fr = 1'b1;
    end
    if (delay != '0) begin
      delay = delay - DW'(1);
      if (delay == '0) begin
        begin_fr = 1'b1;
      end
    end
    frame = begin_fr ? 1'b1 : in_frame_q;
    sbl   = begin_fr ? eff_word : sbl_q;
    cs    = begin_fr ? '0 : cs_q;

    ramp   = ramp_q[cs];
    oshift = oshift_q[cs];
    obl    = obl_q[cs];
    sl     = sl_q[cs];
    ishift = ishift_q[cs];
    ibl    = ibl_q[cs];
    dbit   = (lines_q[3:2] == LINE_ONE);
    msb    = IW'(eff_word - BW'(1));
    nxt    = SCW'(cs) + SCW'(1);

    if (fire && clk_lvl_q) begin
      last_ws_d  = ws_q;
      delay_d    = delay;
      in_frame_d = frame;
      sbl_d      = sbl;
      cs_d       = cs;
      if (frame) begin
        if (SCW'(cs) >= eff_slots) begin
          in_frame_d = 1'b0;
        end else begin
          has_res = 1'b1;
          sslot_d = 3'(cs);

          // capture runs before the slot restarts its word
          if (tx_vec[cs] && ibl != '0) begin
            ibl    = ibl - BW'(1);
            ishift = {ishift[SAMPLE_WIDTH-2:0], dbit};
            if (ibl == '0) begin
              svalid_d = 1'b1;
              svalue_d = ishift;
              ibl      = eff_word;
            end
          end

          if (sbl == eff_word) begin
            if (rx_vec[cs] && ((!sl[LimitWidth-1] && sl != '0) || sl == '1)) begin
              obl    = eff_word;
              oshift = ramp[SAMPLE_WIDTH-1:0];
              if ((pat_end_q - ramp) <= pat_step_q) begin
                ramp = pat_start_q;
              end else begin
                ramp = ramp + pat_step_q;
              end
              if (!sl[LimitWidth-1] && sl != '0) begin
                sl = sl - LimitWidth'(1);
              end
            end
            if (tx_vec[cs]) begin
              ishift = '0;
              ibl    = eff_word;
            end
          end

          if (!rx_vec[cs]) begin
            drive_d = DRIVE_X;
          end else if (obl != '0) begin
            drive_d = {1'b0, oshift[msb]};
            obl     = obl - BW'(1);
            oshift  = {oshift[SAMPLE_WIDTH-2:0], 1'b0};
          end else begin
            drive_d = DRIVE_X;
            // ramp exhausted: slot drops out of the pattern
            if (sl == '0) begin
              for (int i = 0; i < MaskWidth; i++) begin
                if (i < MAX_SLOTS && SW'(i) == cs) begin
                  rx_mask_d[i] = 1'b0;
                end
              end
            end
          end

          ramp_d[cs]   = ramp;
          oshift_d[cs] = oshift;
          obl_d[cs]    = obl;
          sl_d[cs]     = sl;
          ishift_d[cs] = ishift;
          ibl_d[cs]    = ibl;

          if (sbl <= BW'(1)) begin
            sbl_d = eff_word;
            if (nxt >= eff_slots) begin
              in_frame_d = 1'b0;
              cs_d       = '0;
            end else begin
              cs_d = SW'(nxt);
            end
          end else begin
            sbl_d = sbl - BW'(1);
          end
        end
      end
    end

    rising = cfg_wdata_i[MaskWidth-1:0] & ~rx_mask_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WORD_LEN:   wlen_d       = cfg_wdata_i[5:0];
        REG_SLOT_COUNT: slot_count_d = cfg_wdata_i[3:0];
        REG_RX_MASK: begin
          rx_mask_d = cfg_wdata_i[MaskWidth-1:0];
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i < MaskWidth && rising[i % MaskWidth]) begin
              ramp_d[i] = pat_start_q;
              sl_d[i]   = limit_q;
              obl_d[i]  = '0;
            end
          end
        end
        REG_TX_MASK:    tx_mask_d   = cfg_wdata_i[MaskWidth-1:0];
        REG_PAT_START:  pat_start_d = cfg_wdata_i;
        REG_PAT_END:    pat_end_d   = cfg_wdata_i;
        REG_PAT_STEP:   pat_step_d  = cfg_wdata_i;
        REG_SAMPLE_LIM: limit_d     = signed'(cfg_wdata_i[LimitWidth-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && has_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= WORD_LEN_RST;
      slot_count_q <= SLOT_COUNT_RST;
      rx_mask_q    <= '0;
      tx_mask_q    <= '0;
      pat_start_q  <= '0;
      pat_end_q    <= PAT_END_RST;
      pat_step_q   <= PAT_STEP_RST;
      limit_q      <= '1;
      s1_valid_q   <= 1'b0;
      last_ws_q    <= 1'b0;
      delay_q      <= '0;
      in_frame_q   <= 1'b0;
      sbl_q        <= '0;
      cs_q         <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        ramp_q[i]   <= '0;
        oshift_q[i] <= '0;
        obl_q[i]    <= '0;
        sl_q[i]     <= '1;
        ishift_q[i] <= '0;
        ibl_q[i]    <= '0;
      end
    end else begin
      wlen_q       <= wlen_d;
      slot_count_q <= slot_count_d;
      rx_mask_q    <= rx_mask_d;
      tx_mask_q    <= tx_mask_d;
      pat_start_q  <= pat_start_d;
      pat_end_q    <= pat_end_d;
      pat_step_q   <= pat_step_d;
      limit_q      <= limit_d;
      s1_valid_q   <= s1_valid_d;
      last_ws_q    <= last_ws_d;
      delay_q      <= delay_d;
      in_frame_q   <= in_frame_d;
      sbl_q        <= sbl_d;
      cs_q         <= cs_d;
      out_valid_q  <= out_valid_d;
      ramp_q       <= ramp_d;
      oshift_q     <= oshift_d;
      obl_q        <= obl_d;
      sl_q         <= sl_d;
      ishift_q     <= ishift_d;
      ibl_q        <= ibl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      clk_lvl_q <= clock_level_i;
      ws_q      <= word_select_i;
      lines_q   <= line_bits_i;
    end
    if (fire && has_res) begin
      drive_q  <= drive_d;
      svalid_q <= svalid_d;
      svalue_q <= svalue_d;
      sslot_q  <= sslot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_value_o  = drive_q;
  assign sample_valid_o = svalid_q;
  assign sample_value_o = svalue_q;
  assign sample_slot_o  = sslot_q;

  `TDMASP_ASSERT_NEXT(a_result_loaded, fire && has_res, out_valid_o,
                      "result edge did not reach the output register")
  `TDMASP_ASSERT_NOW(a_idle_word_zero, out_valid_o && !sample_valid_o, sample_value_o == '0,
                     "sample value nonzero without a completed word")
  `TDMASP_ASSERT_NOW(a_slot_range, 1'b1, SCW'(cs_q) < SCW'(MAX_SLOTS),
                     "current slot beyond slot storage")
  `TDMASP_ASSERT_NOW(a_stall_cause, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i,
                     "input stalled without a blocked result")
  `TDMASP_ASSERT_NOW(a_bits_range, 1'b1, sbl_q <= BW'(SAMPLE_WIDTH),
                     "slot bit counter above sample width")

endmodule

`default_nettype wire

@@ test/tdm_frame_checker.sv @@
`timescale 1ns / 100ps

module tdm_frame_checker
  import tdmasp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [CfgWidth-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 clock_level_i,
  input  logic                 word_select_i,
  input  logic [3:0]           line_bits_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           drive_value_i,
  input  logic                 sample_valid_i,
  input  logic [31:0]          sample_value_i,
  input  logic [2:0]           sample_slot_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam int Slots    = 8;
  localparam int FrameLag = 1;
  localparam int WordMax  = 32;

  typedef struct packed {
    logic [1:0]  drive;
    logic        valid;
    logic [31:0] value;
    logic [2:0]  slot;
  } edge_result_t;

  edge_result_t edge_results_q[$];

  // register copies
  logic [5:0]           wlen;
  logic [3:0]           slot_count;
  logic [MaskWidth-1:0] rx_mask;
  logic [MaskWidth-1:0] tx_mask;
  logic [31:0]          pat_start;
  logic [31:0]          pat_end;
  logic [31:0]          pat_step;
  int                   sample_limit;

  // frame and per-slot state
  logic        last_ws;
  logic        in_frame;
  int          lag_left;
  int          slot_bits_left;
  int          cur_slot;
  logic [31:0] ramp_next    [Slots];
  logic [31:0] out_shift    [Slots];
  int          out_left     [Slots];
  int          samples_left [Slots];
  logic [31:0] in_shift     [Slots];
  int          in_left      [Slots];

  function automatic int word_len();
    if (wlen == 0) return 1;
    if (wlen > WordMax) return WordMax;
    return int'(wlen);
  endfunction

  function automatic int slot_total();
    if (slot_count == 0) return 1;
    if (slot_count > Slots) return Slots;
    return int'(slot_count);
  endfunction

  function automatic void clear_model();
    wlen         = WORD_LEN_RST;
    slot_count   = SLOT_COUNT_RST;
    rx_mask      = '0;
    tx_mask      = '0;
    pat_start    = '0;
    pat_end      = PAT_END_RST;
    pat_step     = PAT_STEP_RST;
    sample_limit = -1;
    last_ws      = 1'b0;
    in_frame     = 1'b0;
    lag_left     = 0;
    slot_bits_left = 0;
    cur_slot     = 0;
    for (int s = 0; s < Slots; s++) begin
      ramp_next[s]    = pat_start;
      out_shift[s]    = '0;
      out_left[s]     = 0;
      samples_left[s] = sample_limit;
      in_shift[s]     = '0;
      in_left[s]      = 0;
    end
    edge_results_q.delete();
    errors_o  = 0;
    checked_o = 0;
  endfunction

  function automatic void write_reg(input logic [2:0] idx, input logic [31:0] data);
    logic [MaskWidth-1:0] rising;
    case (cfg_reg_e'(idx))
      REG_WORD_LEN:   wlen       = data[5:0];
      REG_SLOT_COUNT: slot_count = data[3:0];
      REG_RX_MASK: begin
        rising  = data[MaskWidth-1:0] & ~rx_mask;
        rx_mask = data[MaskWidth-1:0];
        for (int s = 0; s < Slots; s++) begin
          if (rising[s]) begin
            ramp_next[s]    = pat_start;
            samples_left[s] = sample_limit;
            out_left[s]     = 0;
          end
        end
      end
      REG_TX_MASK:    tx_mask  = data[MaskWidth-1:0];
      REG_PAT_START:  pat_start = data;
      REG_PAT_END:    pat_end   = data;
      REG_PAT_STEP:   pat_step  = data;
      REG_SAMPLE_LIM: sample_limit = $signed(data[LimitWidth-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void open_frame();
    in_frame       = 1'b1;
    slot_bits_left = word_len();
    cur_slot       = 0;
  endfunction

  // loads the next ramp sample and rearms capture at the first bit of a slot
  function automatic void load_word(input int s);
    int          w;
    logic [31:0] headroom;
    w = word_len();
    headroom = pat_end - ramp_next[s];
    if (rx_mask[s] && (samples_left[s] > 0 || samples_left[s] == -1)) begin
      out_left[s]  = w;
      out_shift[s] = ramp_next[s];
      ramp_next[s] = (headroom <= pat_step) ? pat_start : ramp_next[s] + pat_step;
      if (samples_left[s] > 0) samples_left[s]--;
    end
    if (tx_mask[s]) begin
      in_shift[s] = '0;
      in_left[s]  = w;
    end
  endfunction

  function automatic void predict_edge(input logic lvl, input logic ws,
                                       input logic [3:0] line);
    int           w;
    int           n;
    int           s;
    logic         line_bit;
    logic         got_word;
    logic [31:0]  word;
    logic [1:0]   drv;
    edge_result_t res;
    if (!lvl) return;
    w = word_len();
    n = slot_total();
    line_bit = (line[3:2] == LINE_ONE);
    if (ws && !last_ws) begin
      lag_left = FrameLag;
      if (lag_left == 0) open_frame();
    end
    if (lag_left > 0) begin
      lag_left--;
      if (lag_left == 0) open_frame();
    end
    last_ws = ws;
    if (!in_frame) return;
    if (cur_slot >= n) begin
      in_frame = 1'b0;
      return;
    end
    s = cur_slot;

    // capture runs before the word restart, hence the one-bit skew
    got_word = 1'b0;
    word     = '0;
    if (tx_mask[s] && in_left[s] != 0) begin
      in_left[s]--;
      in_shift[s] = {in_shift[s][30:0], line_bit};
      if (in_left[s] == 0) begin
        word       = in_shift[s];
        in_left[s] = w;
        got_word   = 1'b1;
      end
    end
    if (slot_bits_left == w) load_word(s);

    if (!rx_mask[s]) begin
      drv = DRIVE_X;
    end else if (out_left[s] > 0) begin
      drv = {1'b0, out_shift[s][w-1]};
      out_left[s]--;
      out_shift[s] = out_shift[s] << 1;
    end else begin
      // ramp used up: the slot drops out of the drive mask
      if (samples_left[s] == 0) rx_mask[s] = 1'b0;
      drv = DRIVE_X;
    end

    if (slot_bits_left <= 1) begin
      slot_bits_left = w;
      cur_slot++;
      if (cur_slot >= n) begin
        in_frame = 1'b0;
        cur_slot = 0;
      end
    end else begin
      slot_bits_left--;
    end

    res.drive = drv;
    res.valid = got_word;
    res.value = word;
    res.slot  = 3'(s);
    edge_results_q = {edge_results_q, res};
  endfunction

  function automatic void check_result();
    edge_result_t res;
    if (edge_results_q.size() == 0) begin
      $error("unexpected result: drive_value %0d sample_slot %0d", drive_value_i,
             sample_slot_i);
      errors_o++;
      return;
    end
    res = edge_results_q.pop_front();
    if (drive_value_i !== res.drive) begin
      $error("drive_value: expected %0d, actual %0d", res.drive, drive_value_i);
      errors_o++;
    end
    if (sample_valid_i !== res.valid) begin
      $error("sample_valid: expected %0d, actual %0d", res.valid, sample_valid_i);
      errors_o++;
    end
    if (sample_value_i !== res.value) begin
      $error("sample_value: expected %08h, actual %08h", res.value, sample_value_i);
      errors_o++;
    end
    if (sample_slot_i !== res.slot) begin
      $error("sample_slot: expected %0d, actual %0d", res.slot, sample_slot_i);
      errors_o++;
    end
    checked_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && in_ready_i) predict_edge(clock_level_i, word_select_i, line_bits_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= edge_results_q.size();
    end
  end

endmodule

@@ test/tb_tdm_audio_slot_pattern_and_capture.sv @@
`timescale 1ns / 100ps

module tb_tdm_audio_slot_pattern_and_capture;
  import tdmasp_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [2:0]          cfg_index_i   = '0;
  logic [CfgWidth-1:0] cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                clock_level_i = 1'b0;
  logic                word_select_i = 1'b0;
  logic [3:0]          line_bits_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [1:0]          drive_value_o;
  logic                sample_valid_o;
  logic [31:0]         sample_value_o;
  logic [2:0]          sample_slot_o;

  int errors;
  int pending;
  int checked;
  int send_idle_pct = 38;
  int recv_idle_pct = 53;
  int requests      = 0;
  int settings      = 0;
  int frame_edges   = 1;

  tdm_audio_slot_pattern_and_capture u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .clock_level_i  (clock_level_i),
    .word_select_i  (word_select_i),
    .line_bits_i    (line_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_value_o  (drive_value_o),
    .sample_valid_o (sample_valid_o),
    .sample_value_o (sample_value_o),
    .sample_slot_o  (sample_slot_o)
  );

  tdm_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .clock_level_i  (clock_level_i),
    .word_select_i  (word_select_i),
    .line_bits_i    (line_bits_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_value_i  (drive_value_o),
    .sample_valid_i (sample_valid_o),
    .sample_value_i (sample_value_o),
    .sample_slot_i  (sample_slot_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_edge(input logic lvl, input logic ws, input logic [3:0] line);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    clock_level_i <= lvl;
    word_select_i <= ws;
    line_bits_i   <= line;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests++;
  endtask

  // pending is a registered copy of the checker's queue size, so wait before polling it
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // unused upper bits get random noise
  task automatic set_reg(input cfg_reg_e idx, input logic [31:0] val, input int bits);
    logic [31:0] keep;
    keep = (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= (val & keep) | ($urandom() & ~keep);
    @(posedge clk_i);
  endtask

  task automatic configure(input int w, input int n, input logic [7:0] rxm,
                           input logic [7:0] txm, input logic [31:0] st,
                           input logic [31:0] en, input logic [31:0] stp,
                           input logic [16:0] lim, input bit restart);
    int ew;
    int en_slots;
    drain();
    set_reg(REG_WORD_LEN, w, 6);
    set_reg(REG_SLOT_COUNT, n, 4);
    set_reg(REG_TX_MASK, txm, 8);
    set_reg(REG_PAT_START, st, 32);
    set_reg(REG_PAT_END, en, 32);
    set_reg(REG_PAT_STEP, stp, 32);
    set_reg(REG_SAMPLE_LIM, lim, 17);
    if (restart) set_reg(REG_RX_MASK, '0, 8);
    set_reg(REG_RX_MASK, rxm, 8);
    cfg_we_i <= 1'b0;
    ew = (w % 64 == 0) ? 1 : ((w % 64 > 32) ? 32 : w % 64);
    en_slots = (n % 16 == 0) ? 1 : ((n % 16 > 8) ? 8 : n % 16);
    frame_edges = ew * en_slots;
    settings++;
  endtask

  // mostly well-formed frames with random data, some noise bursts
  task automatic run_phase(input int budget);
    int   sent;
    int   len;
    int   hold;
    int   gap;
    int   k;
    logic lvl;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          lvl = $urandom_range(0, 1);
          send_edge(lvl, $urandom_range(0, 1), $urandom_range(0, 15));
          sent++;
        end
      end else begin
        len  = frame_edges;
        hold = $urandom_range(1, (len > 1) ? len - 1 : 1);
        for (int e = 0; e < len && sent < budget; e++) begin
          send_edge(1'b1, e < hold, $urandom_range(0, 15));
          sent++;
          if ($urandom_range(0, 99) < 35) begin
            send_edge(1'b0, $urandom_range(0, 1), $urandom_range(0, 15));
            sent++;
          end
        end
        gap = $urandom_range((len == 1) ? 1 : 0, 2);
        repeat (gap) begin
          send_edge(1'b1, 1'b0, $urandom_range(0, 15));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int          w;
    int          n;
    logic [31:0] st;
    logic [31:0] stp;
    logic [31:0] en;
    logic [16:0] lim;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short frames: ramp wraps on its first sample, limit of two runs out
    configure(2, 2, 8'h03, 8'hFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1, 17'd2, 1'b1);
    send_edge(1'b0, 1'b1, 4'hF);
    send_edge(1'b1, 1'b0, 4'h0);
    for (int f = 0; f < 4; f++) begin
      for (int e = 0; e < 4; e++) begin
        send_edge(1'b1, e == 0, 4'(f * 4 + e));
      end
    end

    for (int ph = 1; ph <= 13; ph++) begin
      if (ph <= 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 53;
      end else if (ph <= 8) begin
        send_idle_pct = 53;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        1: begin
          configure(1, 1, 8'hFF, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1);
          run_phase(90);
        end
        2: begin
          // oversized word and slot count clamp to the maximum
          configure(63, 15, 8'hA5, 8'h5A, 32'hFFFF_FFFF, 32'h0, 32'h0, 17'h0FFFF, 1'b1);
          run_phase(260);
        end
        3: begin
          // zero word and slot count act as one; zero limit drives X
          configure(0, 0, 8'h01, 8'h01, 32'd5, 32'd7, 32'd1, 17'd0, 1'b1);
          run_phase(60);
        end
        4: begin
          configure(3, 3, 8'hFF, 8'h00, $urandom(), $urandom(), 32'd3, 17'h10000, 1'b1);
          run_phase(90);
        end
        5: begin
          configure(2, 8, 8'h00, 8'hFF, 32'd0, 32'd9, 32'd2, 17'd2, 1'b0);
          run_phase(90);
        end
        default: begin
          w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 63);
          n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 15);
          case ($urandom_range(0, 3))
            0: stp = $urandom_range(0, 3);
            1: stp = $urandom();
            2: stp = '1;
            default: stp = $urandom_range(1, 40);
          endcase
          st = $urandom();
          en = st + stp * $urandom_range(0, 4) + $urandom_range(0, 1);
          case ($urandom_range(0, 3))
            0: lim = '1;
            1: lim = $urandom_range(0, 6);
            2: lim = $urandom();
            default: lim = $urandom_range(1, 3);
          endcase
          configure(w, n, $urandom(), $urandom(), st, en, stp, lim,
                    $urandom_range(0, 9) < 6);
          run_phase(82);
        end
      endcase
    end

    drain();
    $display("summary: %0d edge requests over %0d register settings, %0d results checked",
             requests, settings, checked);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tdmasp_pkg.sv
hdl/tdm_audio_slot_pattern_and_capture.sv
test/tdm_frame_checker.sv
test/tb_tdm_audio_slot_pattern_and_capture.sv
